[hw/rtl/rmst_pkg.sv]
// rmst_pkg: shared constants and operation codes for the range minimum segment tree
// no dependencies; imported by range_min_segment_tree, rmst_port_props, rmst_checker and tb

package rmst_pkg;

    // field widths
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 62;
    localparam int ENTRY_W = VAL_W + 1;

    // tree geometry: node 1 is the root, leaf i sits at LEAVES + i
    localparam int LEAVES  = 1024;
    localparam int NODES   = 2 * LEAVES;
    localparam int NODE_W  = $clog2(NODES);
    localparam int PTR_W   = NODE_W + 1;

    // empty marker, above any stored value
    localparam logic [ENTRY_W-1:0] EMPTY_MARK = {ENTRY_W{1'b1}};

    // operation codes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

endpackage

[hw/rtl/range_min_segment_tree.sv]
// range_min_segment_tree: minimum segment tree over LEAVES slots with update, query, clear
// depends on rmst_pkg
//
// Usage: present operation, first_index, last_index and value with start high; the beat
// is taken at a rising edge where start is high and busy is low. Each beat gives exactly
// one result: done is high for one cycle with min_value and is_empty, and the result is
// taken at the edge that ends that cycle. The receiver cannot stall.
// Walks: an update reads the leaf, then climbs one level of the tree per cycle, the
// sibling read for the next level overlapping the parent write. A query climbs the
// tree level by level, reading the left and then the right range end, as both range
// ends share the single memory read port. A clear sweeps all 2048 nodes, one per cycle,
// and then reports. Items that need no tree walk (a reversed query range, unused
// code) report in the next cycle. All walks use one shared min comparator.
// Reset: an asynchronous reset starts the same clearing pass; busy stays high
// until it ends and no result is given for it.
// A result may be shown in the same cycle that the next beat is taken.

module range_min_segment_tree
    import rmst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [IDX_W-1:0]   first_index,
    input  logic [IDX_W-1:0]   last_index,
    input  logic [VAL_W-1:0]   value,
    output logic               done,
    output logic [VAL_W-1:0]   min_value,
    output logic               is_empty
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_U_READ,
        S_U_LEAF,
        S_U_UP,
        S_Q_A,
        S_Q_B
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    a_reg, a_next;
    logic [PTR_W-1:0]    b_reg, b_next;
    logic [ENTRY_W-1:0]  acc_reg, acc_next;
    logic                pend_reg, pend_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic                clr_reply_reg, clr_reply_next;
    logic                done_reg, done_next;
    logic [VAL_W-1:0]    min_value_reg, min_value_next;
    logic                is_empty_reg, is_empty_next;

    // node memory
    logic [ENTRY_W-1:0]  node_mem [NODES];
    logic [ENTRY_W-1:0]  rdata_reg;
    logic [NODE_W-1:0]   raddr;
    logic [NODE_W-1:0]   waddr;
    logic [ENTRY_W-1:0]  wdata;
    logic                we;

    // shared min unit and helpers
    logic [ENTRY_W-1:0]  fold_min;
    logic [ENTRY_W-1:0]  acc_fold;
    logic [PTR_W-1:0]    first_ext;
    logic [PTR_W-1:0]    last_ext;
    logic [PTR_W-1:0]    last_clamp;
    logic [PTR_W-1:0]    parent;
    logic [PTR_W-1:0]    b_dec;

    assign fold_min   = (rdata_reg < acc_reg) ? rdata_reg : acc_reg;
    assign acc_fold   = pend_reg ? fold_min : acc_reg;
    assign first_ext  = PTR_W'(first_index);
    assign last_ext   = PTR_W'(last_index);
    assign last_clamp = (last_ext >= PTR_W'(LEAVES)) ? PTR_W'(LEAVES - 1) : last_ext;
    assign parent     = a_reg >> 1;
    assign b_dec      = b_reg - PTR_W'(1);

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            node_mem[waddr] <= wdata;
        end
        rdata_reg <= node_mem[raddr];
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        clr_next       = clr_reg;
        clr_reply_next = clr_reply_reg;
        done_next      = 1'b0;
        min_value_next = '0;
        is_empty_next  = 1'b1;
        raddr          = a_reg[NODE_W-1:0];
        we             = 1'b0;
        waddr          = clr_reg;
        wdata          = EMPTY_MARK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_UPDATE:
                        begin
                            if (first_ext < PTR_W'(LEAVES))
                            begin
                                a_next     = PTR_W'(LEAVES) + first_ext;
                                acc_next   = {1'b0, value};
                                state_next = S_U_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            if ((first_ext < PTR_W'(LEAVES)) && (first_ext <= last_clamp))
                            begin
                                a_next     = PTR_W'(LEAVES) + first_ext;
                                b_next     = PTR_W'(LEAVES) + last_clamp + PTR_W'(1);
                                acc_next   = EMPTY_MARK;
                                state_next = S_Q_A;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clr_next       = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // sweep every node back to empty
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + NODE_W'(1);
                if (clr_reg == NODE_W'(NODES - 1))
                begin
                    state_next     = S_IDLE;
                    done_next      = clr_reply_reg;
                    clr_reply_next = 1'b0;
                end
            end

            // fetch the leaf
            S_U_READ:
            begin
                raddr      = a_reg[NODE_W-1:0];
                state_next = S_U_LEAF;
            end

            // fold into leaf, fetch its sibling
            S_U_LEAF:
            begin
                acc_next   = fold_min;
                we         = 1'b1;
                waddr      = a_reg[NODE_W-1:0];
                wdata      = fold_min;
                raddr      = a_reg[NODE_W-1:0] ^ NODE_W'(1);
                state_next = S_U_UP;
            end

            // one level per cycle: write parent, fetch parent's sibling
            S_U_UP:
            begin
                acc_next = fold_min;
                we       = 1'b1;
                waddr    = parent[NODE_W-1:0];
                wdata    = fold_min;
                raddr    = parent[NODE_W-1:0] ^ NODE_W'(1);
                a_next   = parent;
                if (parent == PTR_W'(1))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            // query: left end of the level, or finish
            S_Q_A:
            begin
                acc_next = acc_fold;
                if (a_reg < b_reg)
                begin
                    if (a_reg[0])
                    begin
                        raddr     = a_reg[NODE_W-1:0];
                        pend_next = 1'b1;
                        a_next    = a_reg + PTR_W'(1);
                    end
                    state_next = S_Q_B;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (acc_fold != EMPTY_MARK)
                    begin
                        min_value_next = acc_fold[VAL_W-1:0];
                        is_empty_next  = 1'b0;
                    end
                end
            end

            // query: right end of the level, then climb
            S_Q_B:
            begin
                acc_next = acc_fold;
                if (b_reg[0])
                begin
                    raddr     = b_dec[NODE_W-1:0];
                    pend_next = 1'b1;
                end
                a_next     = a_reg >> 1;
                b_next     = b_reg >> 1;
                state_next = S_Q_A;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clr_reply_reg <= 1'b0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_reply_reg <= clr_reply_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        acc_reg       <= acc_next;
        min_value_reg <= min_value_next;
        is_empty_reg  <= is_empty_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign min_value = min_value_reg;
    assign is_empty  = is_empty_reg;

endmodule

[hw/rtl/rmst_checker.sv]
// rmst_port_props: port-level checks on the range minimum segment tree, bound to the top level
// depends on rmst_pkg and range_min_segment_tree

module rmst_port_props
    import rmst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         operation,
    input  logic               done,
    input  logic [VAL_W-1:0]   min_value,
    input  logic               is_empty
);

    // an accepted beat either keeps the block busy or reports at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither started work nor reported");

    // a result only follows an accepted beat or a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without work behind it");

    // an empty result carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> (min_value == '0))
        else $error("empty result with nonzero value");

    // a clear always sweeps the tree
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_CLEAR)) |=> (busy && !done))
        else $error("clear reported without a sweep");

endmodule

bind range_min_segment_tree rmst_port_props u_rmst_port_props (.*);

[verif/rmst_checker.sv]
`timescale 1ns / 100ps
// rmst_checker: watches the command and result channels of range_min_segment_tree,
// predicts each result from its own copy of the leaf values and compares it
// depends on rmst_pkg

module rmst_checker
    import rmst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       operation,
    input  logic [IDX_W-1:0] first_index,
    input  logic [IDX_W-1:0] last_index,
    input  logic [VAL_W-1:0] value,
    input  logic             done,
    input  logic [VAL_W-1:0] min_value,
    input  logic             is_empty,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [VAL_W-1:0] min_value;
        logic             is_empty;
    } min_answer_t;

    // leaf values only: a range minimum is a plain scan over the leaves
    logic [ENTRY_W-1:0] leaf_min [LEAVES];
    min_answer_t        answer_q [$];
    int                 error_count = 0;

    function automatic void empty_leaves();
        for (int i = 0; i < LEAVES; i++)
            leaf_min[i] = EMPTY_MARK;
    endfunction

    // apply one command beat to the leaf copy and return the answer it should give
    function automatic min_answer_t apply_beat(logic [1:0] op, logic [IDX_W-1:0] lo,
                                               logic [IDX_W-1:0] hi, logic [VAL_W-1:0] v);
        min_answer_t        ans;
        logic [ENTRY_W-1:0] best;
        int                 top;
        ans.min_value = '0;
        ans.is_empty  = 1'b1;
        case (op)
            OP_UPDATE:
            begin
                // a leaf only ever moves down
                if (int'(lo) < LEAVES && {1'b0, v} < leaf_min[lo])
                    leaf_min[lo] = {1'b0, v};
            end
            OP_QUERY:
            begin
                // upper end clamped to the last leaf; a reversed range scans nothing
                top  = (int'(hi) >= LEAVES) ? LEAVES - 1 : int'(hi);
                best = EMPTY_MARK;
                for (int i = int'(lo); i <= top; i++)
                begin
                    if (leaf_min[i] < best)
                        best = leaf_min[i];
                end
                if (best != EMPTY_MARK)
                begin
                    ans.min_value = best[VAL_W-1:0];
                    ans.is_empty  = 1'b0;
                end
            end
            OP_CLEAR:
                empty_leaves();
            default:
                ;
        endcase
        return ans;
    endfunction

    task automatic note_error(string field, logic [VAL_W-1:0] want_v, logic [VAL_W-1:0] got_v);
        error_count++;
        $error("%s: expected %0h, actual %0h", field, want_v, got_v);
    endtask

    initial
        empty_leaves();

    // result beat retires the oldest prediction, then a taken command adds one
    always @(posedge clk)
    begin
        min_answer_t want;
        if (!rst_n)
        begin
            empty_leaves();
            answer_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    error_count++;
                    $error("result beat with no result expected: min_value %0h, is_empty %0b",
                           min_value, is_empty);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (min_value !== want.min_value)
                        note_error("min_value", want.min_value, min_value);
                    if (is_empty !== want.is_empty)
                        note_error("is_empty", VAL_W'(want.is_empty), VAL_W'(is_empty));
                end
            end
            if (start && !busy)
                answer_q.push_back(apply_beat(operation, first_index, last_index, value));
        end
        mismatches  <= error_count;
        outstanding <= answer_q.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// tb: drives commands into range_min_segment_tree and gives the verdict
// depends on rmst_pkg, rmst_checker and the block under test

module tb;
    import rmst_pkg::*;

    localparam logic [1:0]       OP_UNUSED    = 2'd3;
    localparam logic [VAL_W-1:0] VALUE_TOP    = {VAL_W{1'b1}};
    localparam int               CYCLE_LIMIT  = 400000;
    localparam int               DRAIN_CYCLES = 40;
    localparam int               PHASE_BEATS  = 283;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       operation;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
    logic [VAL_W-1:0] value;
    logic             done;
    logic [VAL_W-1:0] min_value;
    logic             is_empty;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int beats_sent  = 0;
    int idle_pct    = 0;
    int phase_end;

    range_min_segment_tree dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .first_index (first_index),
        .last_index  (last_index),
        .value       (value),
        .done        (done),
        .min_value   (min_value),
        .is_empty    (is_empty)
    );

    rmst_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .first_index (first_index),
        .last_index  (last_index),
        .value       (value),
        .done        (done),
        .min_value   (min_value),
        .is_empty    (is_empty),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one command beat, with random idle cycles in front of it
    task automatic send_beat(logic [1:0] op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                             logic [VAL_W-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= op;
        first_index <= lo;
        last_index  <= hi;
        value       <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
    endtask

    // values lean towards the extremes and small numbers so minima collide
    function automatic logic [VAL_W-1:0] draw_value();
        logic [VAL_W-1:0] v;
        v = VAL_W'({$urandom, $urandom});
        case ($urandom_range(5))
            0: v = '0;
            1: v = VALUE_TOP;
            2: v = v >> $urandom_range(VAL_W - 1);
            3: v = VAL_W'($urandom_range(999));
            default: ;
        endcase
        return v;
    endfunction

    // a run of updates and queries around one window of leaves, or a lone clear or unused code
    task automatic run_burst();
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        int               span;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 3)
            send_beat(OP_CLEAR, IDX_W'($urandom), IDX_W'($urandom), draw_value());
        else if (pick < 6)
            send_beat(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), draw_value());
        else
        begin
            base = IDX_W'($urandom);
            case ($urandom_range(2))
                0: span = $urandom_range(1, 8);
                1: span = $urandom_range(1, 64);
                default: span = $urandom_range(1, LEAVES);
            endcase
            repeat ($urandom_range(4, 16))
            begin
                lo = base + IDX_W'($urandom_range(span - 1));
                hi = lo + IDX_W'($urandom_range(span - 1));
                case ($urandom_range(9))
                    0: send_beat(OP_QUERY, '0, '1, draw_value());
                    1: send_beat(OP_QUERY, hi, lo, draw_value());
                    2, 3, 4, 5: send_beat(OP_UPDATE, lo, IDX_W'($urandom), draw_value());
                    default: send_beat(OP_QUERY, lo, hi, draw_value());
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        operation   <= OP_UPDATE;
        first_index <= '0;
        last_index  <= '0;
        value       <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty tree, extreme values and slots, reversed ranges, unused code, clear
        idle_pct = 27;
        send_beat(OP_QUERY, '0, '1, '0);
        send_beat(OP_UPDATE, '0, '1, VALUE_TOP);
        send_beat(OP_QUERY, '0, '0, '1);
        send_beat(OP_UPDATE, '0, '0, 62'd9);
        send_beat(OP_UPDATE, '0, '0, VALUE_TOP);
        send_beat(OP_QUERY, '0, '0, '0);
        send_beat(OP_UPDATE, '1, '0, '0);
        send_beat(OP_QUERY, '1, '1, '0);
        send_beat(OP_QUERY, '0, '1, '0);
        send_beat(OP_QUERY, 10'd1, 10'd1022, '0);
        send_beat(OP_QUERY, 10'd600, 10'd300, '0);
        send_beat(OP_QUERY, '1, '0, '0);
        send_beat(OP_UPDATE, 10'd512, 10'h155, 62'h2AAA_AAAA_AAAA_AAAA);
        send_beat(OP_UPDATE, 10'd511, 10'h2AA, 62'h1555_5555_5555_5555);
        send_beat(OP_QUERY, 10'd500, 10'd600, '0);
        send_beat(OP_QUERY, 10'd512, 10'd700, '0);
        send_beat(OP_UNUSED, '1, '1, VALUE_TOP);
        send_beat(OP_QUERY, '0, '1, '0);
        send_beat(OP_CLEAR, '0, '0, '0);
        send_beat(OP_QUERY, '0, '1, '0);
        send_beat(OP_UPDATE, '1, '1, VALUE_TOP);
        send_beat(OP_QUERY, '1, '1, '0);

        // random: sender idles seldom, then often, then never
        phase_end = beats_sent + PHASE_BEATS;
        while (beats_sent < phase_end)
            run_burst();
        idle_pct  = 64;
        phase_end = beats_sent + PHASE_BEATS;
        while (beats_sent < phase_end)
            run_burst();
        idle_pct  = 0;
        phase_end = beats_sent + PHASE_BEATS;
        while (beats_sent < phase_end)
            run_burst();

        // drain: every result in, then a quiet spell to catch stray beats
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
